>>> sv/smlr_pkg.sv
// shared types and constants for the laplacian row builder
`timescale 1ns / 1ps
package smlr_pkg;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned DIAG_W = 48;

	typedef struct packed {
		logic [VAL_W-1:0] target_distance;
		logic signed [VAL_W-1:0] own_x;
		logic signed [VAL_W-1:0] own_y;
		logic signed [VAL_W-1:0] other_x;
		logic signed [VAL_W-1:0] other_y;
		logic same_vertex;
		logic row_end;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] entry_value;
		logic is_diagonal;
		logic row_last;
		logic saturated;
	} out_item_t;

	// classified job passed from front to back
	typedef struct packed {
		logic [VAL_W-1:0] tdist;
		logic [VAL_W-1:0] ax;
		logic [VAL_W-1:0] ay;
		logic mode;
		logic do_entry;
		logic do_diag;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SUM, ST_SQRT, ST_MUL, ST_DIV, ST_EMIT_E, ST_EMIT_D
	} back_state_t;
endpackage

>>> sv/smlr_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
interface smlr_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/smlr_front.sv
// front end: takes requests, forms absolute differences, two-entry queue
`timescale 1ns / 1ps
module smlr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic mode,
	input  smlr_pkg::in_item_t in_item,
	input  logic in_valid,
	output logic in_ready,
	output smlr_pkg::job_t job,
	output logic job_valid,
	input  logic job_take
);
	import smlr_pkg::*;

	job_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	job_t nj;
	logic push, pop;

	function automatic logic [VAL_W-1:0] adiff(input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W:0] d;
		d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		return d[VAL_W] ? VAL_W'(-d) : d[VAL_W-1:0];
	endfunction

	always_comb begin
		nj.tdist = in_item.target_distance;
		nj.ax = adiff(in_item.own_x, in_item.other_x);
		nj.ay = adiff(in_item.own_y, in_item.other_y);
		nj.mode = mode;
		nj.do_entry = ~in_item.same_vertex;
		nj.do_diag = in_item.row_end;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid & in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid & job_take;
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> sv/smlr_back.sv
// back end: norm by iterative root, product, iterative reciprocal, diagonal sum
`timescale 1ns / 1ps
module smlr_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  smlr_pkg::job_t job,
	input  logic job_valid,
	output logic job_take,
	output smlr_pkg::out_item_t out_item,
	output logic out_valid,
	input  logic out_ready
);
	import smlr_pkg::*;

	localparam int S = 3 * FRAC_BITS;
	localparam logic [DIAG_W-1:0] DIAG_MAX = '1;
	localparam logic [32:0] Q_CAP = 33'h080000001;
	localparam logic [32:0] E_MIN = 33'h080000000;

	back_state_t st_q, st_d;
	job_t j_q;
	logic [63:0] sx_q, sy_q;
	logic [65:0] ssum_q;
	logic [67:0] rem_q;
	logic [32:0] root_q;
	logic [5:0] k_q;
	logic [63:0] p_q;
	logic [64:0] r_q;
	logic [32:0] q_q;
	logic [6:0] i_q;
	logic [6:0] s_q;
	logic [DIAG_W-1:0] diag_q;
	logic ovf_q;
	out_item_t o_q;
	logic ov_q;

	// shared root step
	logic [1:0] pair;
	logic [67:0] rem_sh;
	logic [34:0] trial;
	always_comb begin
		pair = (k_q == 6'd32) ? ssum_q[65:64] : ssum_q[2*k_q[4:0] +: 2];
		rem_sh = {rem_q[65:0], pair};
		trial = {root_q, 2'b01};
	end

	// shared divider step, the numerator's single one enters on the first step
	logic [64:0] r_sh;
	logic ge;
	logic [32:0] q_nx;
	always_comb begin
		r_sh = {r_q[63:0], i_q == s_q};
		ge = r_sh[64] | (r_sh[63:0] >= p_q);
		q_nx = {q_q[31:0], ge};
	end

	logic [DIAG_W:0] dsum;
	logic [32:0] qeff;
	logic emit_sat;
	always_comb begin
		qeff = (q_q > E_MIN) ? E_MIN : q_q;
		dsum = {1'b0, diag_q} + (DIAG_W+1)'(qeff);
		emit_sat = diag_q > DIAG_W'(32'h7FFFFFFF);
	end

	assign out_item = o_q;
	assign out_valid = ov_q;
	assign job_take = (st_q == ST_IDLE) & job_valid;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid) st_d = job.do_entry ? (job.mode ? ST_SQ : ST_MUL)
				: (job.do_diag ? ST_EMIT_D : ST_IDLE);
			ST_SQ: st_d = ST_SUM;
			ST_SUM: st_d = ST_SQRT;
			ST_SQRT: if (k_q == 6'd0) st_d = ST_MUL;
			ST_MUL: st_d = ST_DIV;
			ST_DIV: if (i_q == 7'd0 || ovf_q) st_d = ST_EMIT_E;
			ST_EMIT_E: if (!ov_q) st_d = j_q.do_diag ? ST_EMIT_D : ST_IDLE;
			ST_EMIT_D: if (!ov_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			diag_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (st_q == ST_EMIT_E && !ov_q) begin
				ov_q <= 1'b1;
				diag_q <= dsum[DIAG_W] ? DIAG_MAX : dsum[DIAG_W-1:0];
			end
			if (st_q == ST_EMIT_D && !ov_q) begin
				ov_q <= 1'b1;
				diag_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				j_q <= job;
				rem_q <= '0;
				root_q <= '0;
				k_q <= 6'd32;
			end
			ST_SQ: begin
				sx_q <= j_q.ax * j_q.ax;
				sy_q <= j_q.ay * j_q.ay;
			end
			ST_SUM: ssum_q <= {2'b00, sx_q} + {2'b00, sy_q};
			ST_SQRT: begin
				if (rem_sh >= {33'd0, trial}) begin
					rem_q <= rem_sh - {33'd0, trial};
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[31:0], 1'b0};
				end
				k_q <= k_q - 6'd1;
			end
			ST_MUL: begin
				r_q <= '0;
				q_q <= '0;
				ovf_q <= 1'b0;
				if (!j_q.mode) begin
					p_q <= j_q.tdist * j_q.tdist;
					s_q <= 7'(S);
					i_q <= 7'(S);
				end else if (root_q[32]) begin
					p_q <= j_q.tdist * root_q[32:1]
						+ (root_q[0] ? 64'(j_q.tdist >> 1) : 64'd0);
					s_q <= 7'(S - 1);
					i_q <= 7'(S - 1);
				end else begin
					p_q <= j_q.tdist * root_q[31:0];
					s_q <= 7'(S);
					i_q <= 7'(S);
				end
			end
			ST_DIV: begin
				if (p_q == 64'd0) begin
					q_q <= Q_CAP;
					ovf_q <= 1'b1;
				end else begin
					r_q <= ge ? (r_sh - {1'b0, p_q}) : r_sh;
					if (q_nx > E_MIN || q_q[32]) begin
						q_q <= Q_CAP;
						ovf_q <= 1'b1;
					end else q_q <= q_nx;
					i_q <= i_q - 7'd1;
				end
			end
			ST_EMIT_E: if (!ov_q) begin
				o_q.entry_value <= VAL_W'(-qeff[31:0]);
				o_q.is_diagonal <= 1'b0;
				o_q.row_last <= 1'b0;
				o_q.saturated <= (q_q > E_MIN);
			end
			ST_EMIT_D: if (!ov_q) begin
				o_q.entry_value <= emit_sat ? 32'h7FFFFFFF : diag_q[31:0];
				o_q.is_diagonal <= 1'b1;
				o_q.row_last <= 1'b1;
				o_q.saturated <= emit_sat;
			end
			default: ;
		endcase
	end
endmodule

>>> sv/stress_majorization_laplacian_row_top.sv
// channel   | dir | payload
// in_ch     | in  | target_distance, own/other coordinates, same_vertex, row_end
// out_ch    | out | entry_value, is_diagonal, row_last, saturated
// cfg       | in  | laplacian_mode (cfg_we, cfg_wdata)
// in the back end an item passes only the bit-serial divider in mode 0 and
// the bit-serial root and then the bit-serial divider in mode 1
// the front queue holds two requests so inputs keep flowing while the back works
// the back waits while its output register is still full
// reset clears the mode to 1 and the diagonal sum to zero
`timescale 1ns / 1ps
module stress_majorization_laplacian_row_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	smlr_if.sink in_ch,
	smlr_if.source out_ch
);
	import smlr_pkg::*;

	logic mode_q;
	job_t job;
	logic job_valid, job_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b1;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	smlr_front u_front (
		.clk, .arst_n, .mode(mode_q), .in_item(in_ch.payload), .in_valid(in_ch.valid),
		.in_ready(in_ch.ready), .job, .job_valid, .job_take
	);

	smlr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .job, .job_valid, .job_take, .out_item(out_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);
endmodule

>>> sv/smlr_checker.sv
// port-level checks for the laplacian row builder
`timescale 1ns / 1ps
module smlr_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic is_diagonal,
	input logic row_last,
	input logic saturated,
	input logic [31:0] entry_value
);
	a_diag_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_diagonal == row_last)) else $error("diag/last mismatch");
	a_entry_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_diagonal && !saturated |-> entry_value[31] || entry_value == 32'd0)
		else $error("entry not negative");
	a_diag_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_diagonal |-> !entry_value[31]) else $error("diag negative");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_value))
		else $error("output dropped");
endmodule

bind stress_majorization_laplacian_row_top smlr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.is_diagonal(out_ch.payload.is_diagonal), .row_last(out_ch.payload.row_last),
	.saturated(out_ch.payload.saturated), .entry_value(out_ch.payload.entry_value)
);

>>> sim/tb_stress_majorization_laplacian_row_top.sv
// testbench for the laplacian row builder: random and corner requests, scoreboard predictor
`timescale 1ns / 1ps
module tb_stress_majorization_laplacian_row_top;
	import smlr_pkg::*;

	localparam int FRAC = 16;
	localparam int SETTLE = 3 * FRAC + 160;
	localparam logic [63:0] Q_LIMIT = 64'h8000_0000;
	localparam logic [63:0] DIAG_TOP = (64'd1 << DIAG_W) - 1;
	localparam logic MODE_WEIGHT = 1'b0;
	localparam logic MODE_ITER = 1'b1;

	class laplacian_board;
		out_item_t entries_due[$];
		logic [63:0] diag_acc;
		logic mode;
		int errors;

		function new();
			diag_acc = 0;
			mode = MODE_ITER;
			errors = 0;
		endfunction

		function void set_mode(logic m);
			mode = m;
		endfunction

		// bit-exact prediction of one accepted request
		function void note_request(in_item_t it);
			longint dx, dy;
			logic [63:0] ax, ay, p, q, nrm;
			logic [65:0] sq;
			logic [67:0] rem, trial;
			logic [127:0] quo;
			int s;
			out_item_t r;
			if (!it.same_vertex) begin
				s = 3 * FRAC;
				if (mode == MODE_WEIGHT) begin
					p = {32'd0, it.target_distance} * {32'd0, it.target_distance};
				end else begin
					dx = longint'(it.own_x) - longint'(it.other_x);
					dy = longint'(it.own_y) - longint'(it.other_y);
					ax = dx < 0 ? -dx : dx;
					ay = dy < 0 ? -dy : dy;
					sq = {2'b0, ax * ax} + {2'b0, ay * ay};
					rem = 0;
					nrm = 0;
					for (int k = 32; k >= 0; k--) begin
						rem = (rem << 2) | sq[2*k +: 2];
						trial = {nrm, 2'b01};
						if (rem >= trial) begin
							rem = rem - trial;
							nrm = (nrm << 1) | 1;
						end else begin
							nrm = nrm << 1;
						end
					end
					if (nrm >> 32) begin
						// norm too wide: halve the divisor and the numerator
						p = it.target_distance * (nrm >> 1)
							+ (nrm[0] ? {33'd0, it.target_distance[31:1]} : 64'd0);
						s = s - 1;
					end else begin
						p = it.target_distance * nrm;
					end
				end
				if (p == 0) begin
					quo = Q_LIMIT + 1;
				end else begin
					quo = (128'd1 << s) / {64'd0, p};
				end
				r.saturated = quo > Q_LIMIT;
				q = r.saturated ? Q_LIMIT : quo[63:0];
				r.entry_value = -q[31:0];
				r.is_diagonal = 1'b0;
				r.row_last = 1'b0;
				diag_acc = diag_acc + q;
				if (diag_acc > DIAG_TOP)
					diag_acc = DIAG_TOP;
				entries_due.push_back(r);
			end
			if (it.row_end) begin
				r.saturated = diag_acc > 64'h7FFF_FFFF;
				r.entry_value = r.saturated ? 32'h7FFF_FFFF : diag_acc[31:0];
				r.is_diagonal = 1'b1;
				r.row_last = 1'b1;
				diag_acc = 0;
				entries_due.push_back(r);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (entries_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = entries_due.pop_front();
			if (got.entry_value !== exp_r.entry_value) begin
				$display("%0t: entry_value expected %h actual %h", $time,
					exp_r.entry_value, got.entry_value);
				errors++;
			end
			if (got.is_diagonal !== exp_r.is_diagonal) begin
				$display("%0t: is_diagonal expected %b actual %b", $time,
					exp_r.is_diagonal, got.is_diagonal);
				errors++;
			end
			if (got.row_last !== exp_r.row_last) begin
				$display("%0t: row_last expected %b actual %b", $time,
					exp_r.row_last, got.row_last);
				errors++;
			end
			if (got.saturated !== exp_r.saturated) begin
				$display("%0t: saturated expected %b actual %b", $time,
					exp_r.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic gaps_on;
	laplacian_board board;

	smlr_if #(.payload_t(in_item_t)) in_ch ();
	smlr_if #(.payload_t(out_item_t)) out_ch ();

	stress_majorization_laplacian_row_top #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// result side: random stall bursts while gaps are on
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				board.check_result(out_ch.payload);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 11) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(in_item_t it);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		board.note_request(it);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.entries_due.size() != 0) @(posedge clk);
		// a same-vertex request may still be in flight with no result
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_mode(m);
	endtask

	function automatic in_item_t make_item(logic [31:0] d, logic [31:0] xi, logic [31:0] yi,
		logic [31:0] xj, logic [31:0] yj, logic same, logic last);
		in_item_t it;
		it.target_distance = d;
		it.own_x = xi;
		it.own_y = yi;
		it.other_x = xj;
		it.other_y = yj;
		it.same_vertex = same;
		it.row_end = last;
		return it;
	endfunction

	function automatic logic [31:0] rand_distance();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom();
			2: return $urandom_range(1, 255);
			default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 5) == 0)
			return $urandom();
		return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
	endfunction

	task automatic random_rows(int count, logic wild);
		int sent;
		int len;
		logic [31:0] xi, yi;
		logic same;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 7);
			xi = rand_coord();
			yi = rand_coord();
			for (int c = 0; c < len; c++) begin
				same = $urandom_range(0, 6) == 0;
				// occasional noise: stray row ends and coincident points
				if (wild && $urandom_range(0, 9) == 0)
					send_request(make_item(rand_distance(), xi, yi, xi, yi, same,
						1'($urandom_range(0, 1))));
				else
					send_request(make_item(rand_distance(), xi, yi, rand_coord(),
						rand_coord(), same, c == len - 1));
				sent++;
			end
		end
	endtask

	initial begin
		board = new();
		gaps_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// iterative mode from reset: coincident points, huge spread, unit case
		send_request(make_item(32'h0001_0000, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0));
		send_request(make_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
		send_request(make_item(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'd0, 32'h0003_0000, 0, 0, 32'h0004_0000, 1'b0, 1'b0));
		send_request(make_item(32'h0000_0100, 0, 0, 32'h0000_0100, 0, 1'b0, 1'b0));
		send_request(make_item(32'h0001_0000, 0, 0, 0, 0, 1'b1, 1'b1));
		// empty row
		send_request(make_item(32'h0001_0000, 0, 0, 0, 0, 1'b1, 1'b1));
		send_request(make_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0));

		write_mode(MODE_WEIGHT);
		send_request(make_item(32'd0, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'd1, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'h0001_0000, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'hFFFF_FFFF, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'h0000_0100, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'h0000_8000, 0, 0, 0, 0, 1'b0, 1'b1));
		// diagonal clipped after two saturated entries
		send_request(make_item(32'd0, 0, 0, 0, 0, 1'b0, 1'b0));
		send_request(make_item(32'd0, 0, 0, 0, 0, 1'b0, 1'b1));
		send_request(make_item(32'h0000_0100, 0, 0, 0, 0, 1'b1, 1'b1));

		random_rows(250, 1'b1);
		write_mode(MODE_ITER);
		random_rows(250, 1'b1);
		drain();
		random_rows(150, 1'b1);
		write_mode(MODE_WEIGHT);
		random_rows(100, 1'b0);
		write_mode(MODE_ITER);
		gaps_on = 1'b0;
		random_rows(150, 1'b0);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.entries_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.entries_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
